>>> hw/rtl/axis_calibrate_lowpass_macros.svh
// ----------------------------------------------------------------------------
// axis calibrate lowpass assertion macros
// concurrent property helpers used by the checker file acl_checker.sv
// ----------------------------------------------------------------------------
`ifndef AXIS_CALIBRATE_LOWPASS_MACROS_SVH
`define AXIS_CALIBRATE_LOWPASS_MACROS_SVH

// antecedent and consequent in the same cycle
`define ACL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acl check failed");

// consequent in the cycle after the antecedent
`define ACL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acl check failed");

`endif

>>> hw/rtl/acl_pkg.sv
// ----------------------------------------------------------------------------
// acl_pkg
// types, widths and constants of the calibrate and low-pass block
// ----------------------------------------------------------------------------
package acl_pkg;

  // output span in signed Q16, defaults are -1.0 and +1.0
  localparam int OUT_MIN = -65536;
  localparam int OUT_MAX = 65536;

  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = $clog2(NUM_AXES);
  localparam int DATA_W     = 24;
  localparam int RAW_W      = 16;
  localparam int SPAN_W     = RAW_W + 1;
  localparam int DEN_W      = RAW_W;
  localparam int MUL_W      = DATA_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int NUM_W      = 42;
  localparam int QUOT_W     = NUM_W + 1;
  localparam int K_W        = 17;
  localparam int K_FRAC     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic signed [MUL_W-1:0]  OUT_SPAN   = MUL_W'(OUT_MAX - OUT_MIN);
  localparam logic signed [DATA_W-1:0] OUT_MIN_V  = DATA_W'(OUT_MIN);
  localparam logic [K_W-1:0]           K_ONE      = K_W'(1 << K_FRAC);
  localparam logic [K_W-1:0]           K_RESET    = K_W'(6554);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (K_FRAC - 1));
  localparam logic signed [PROD_W-1:0] SAT_HI     = PROD_W'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO     = -PROD_W'(1 << (DATA_W - 1));

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_Z = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LPF_K     = 3'd6;

  typedef struct packed {
    logic [7:0] frame_byte_0;
    logic [7:0] frame_byte_1;
    logic [7:0] frame_byte_2;
    logic [7:0] frame_byte_3;
    logic [7:0] frame_byte_4;
    logic [7:0] frame_byte_5;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mapped_x;
    logic signed [DATA_W-1:0] mapped_y;
    logic signed [DATA_W-1:0] mapped_z;
    logic signed [DATA_W-1:0] filtered_x;
    logic signed [DATA_W-1:0] filtered_y;
    logic signed [DATA_W-1:0] filtered_z;
    logic [2:0]               span_error;
  } out_item_t;

  // divider request and response
  typedef struct packed {
    logic                     start;
    logic signed [NUM_W-1:0]  num;
    logic signed [SPAN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [QUOT_W-1:0] quot;
  } div_rsp_t;

  // clamp a wide signed value to the 24-bit field range
  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/acl_mul.sv
// ----------------------------------------------------------------------------
// acl_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module acl_mul import acl_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> hw/rtl/acl_div.sv
// ----------------------------------------------------------------------------
// acl_div
// iterative signed divider, two quotient bits per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module acl_div import acl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int ITER  = NUM_W / 2;
  localparam int CNT_W = $clog2(ITER);

  logic                     busy_q;
  logic                     done_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     neg_q;
  logic [DEN_W-1:0]         den_q;
  logic [DEN_W-1:0]         rem_q;
  logic [NUM_W-1:0]         dvd_q;
  logic signed [QUOT_W-1:0] quot_q;

  logic [NUM_W-1:0]         num_mag;
  logic [SPAN_W-1:0]        den_abs;
  logic [DEN_W-1:0]         rem_v;
  logic [NUM_W-1:0]         dvd_v;
  logic [DEN_W:0]           trial;
  logic                     ge;
  logic signed [QUOT_W-1:0] quot_v;

  // operand magnitudes
  assign num_mag = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : NUM_W'(req_i.num);
  assign den_abs = req_i.den[SPAN_W-1] ? SPAN_W'(-req_i.den) : SPAN_W'(req_i.den);

  // two restoring steps, quotient bits shift into the dividend register
  always_comb begin
    rem_v = rem_q;
    dvd_v = dvd_q;
    trial = '0;
    ge    = 1'b0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_v, dvd_v[NUM_W-1]};
      ge    = trial >= {1'b0, den_q};
      if (ge) begin
        trial = trial - {1'b0, den_q};
      end
      rem_v = trial[DEN_W-1:0];
      dvd_v = {dvd_v[NUM_W-2:0], ge};
    end
    quot_v = neg_q ? -$signed({1'b0, dvd_v}) : $signed({1'b0, dvd_v});
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(ITER - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= num_mag;
      rem_q <= '0;
      den_q <= den_abs[DEN_W-1:0];
      neg_q <= req_i.num[NUM_W-1] ^ req_i.den[SPAN_W-1];
    end else if (busy_q) begin
      dvd_q <= dvd_v;
      rem_q <= rem_v;
      if (cnt_q == '0) begin
        quot_q <= quot_v;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

>>> hw/rtl/axis_calibrate_lowpass.sv
// ----------------------------------------------------------------------------
// axis_calibrate_lowpass
// Takes one six-byte frame of three little-endian signed 16-bit readings,
// maps each axis linearly from its calibrated span onto the output span in
// signed Q16 (no clamping, result saturated to 24 bits; a zero span gives the
// output minimum and sets that axis's span_error bit) and runs it through a
// first-order low-pass with coefficient lpf_k in Q1.16. Per axis, the
// iterative divider turns the scaled offset into the mapped value and the
// shared multiplier forms both the scaled offset and the filter step; a
// zero-span axis skips the divider. A result waits in an output register,
// and the next item can be taken from the cycle after the previous result
// is loaded. Configuration must be written only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module axis_calibrate_lowpass import acl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_DIV_WAIT,
    ST_FLT_MUL,
    ST_FLT_UPD,
    ST_DONE
  } state_e;

  state_e                   state_q;
  logic [AXIS_W-1:0]        axis_q;
  in_item_t                 in_q;
  logic signed [DATA_W-1:0] mapped_q [NUM_AXES];
  logic signed [DATA_W-1:0] fv_q     [NUM_AXES];
  logic [2:0]               err_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  logic signed [RAW_W-1:0]  cal_lo_q [NUM_AXES];
  logic signed [RAW_W-1:0]  cal_hi_q [NUM_AXES];
  logic [K_W-1:0]           k_q;

  logic signed [RAW_W-1:0]  raw      [NUM_AXES];
  logic signed [SPAN_W-1:0] offset;
  logic signed [SPAN_W-1:0] span;
  logic signed [MUL_W-1:0]  diff;
  logic [K_W-1:0]           k_eff;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] step;
  logic signed [PROD_W-1:0] upd;
  logic signed [PROD_W-1:0] map_sum;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cal_lo_q[a] <= '0;
        cal_hi_q[a] <= '0;
      end
      k_q <= K_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAL_MIN_X: cal_lo_q[0] <= cfg_data_i[RAW_W-1:0];
        REG_CAL_MAX_X: cal_hi_q[0] <= cfg_data_i[RAW_W-1:0];
        REG_CAL_MIN_Y: cal_lo_q[1] <= cfg_data_i[RAW_W-1:0];
        REG_CAL_MAX_Y: cal_hi_q[1] <= cfg_data_i[RAW_W-1:0];
        REG_CAL_MIN_Z: cal_lo_q[2] <= cfg_data_i[RAW_W-1:0];
        REG_CAL_MAX_Z: cal_hi_q[2] <= cfg_data_i[RAW_W-1:0];
        REG_LPF_K:     k_q         <= cfg_data_i[K_W-1:0];
        default: ;
      endcase
    end
  end

  // raw readings from the captured frame
  assign raw[0] = {in_q.frame_byte_1, in_q.frame_byte_0};
  assign raw[1] = {in_q.frame_byte_3, in_q.frame_byte_2};
  assign raw[2] = {in_q.frame_byte_5, in_q.frame_byte_4};

  // per-axis operands
  assign offset = SPAN_W'(raw[axis_q]) - SPAN_W'(cal_lo_q[axis_q]);
  assign span   = SPAN_W'(cal_hi_q[axis_q]) - SPAN_W'(cal_lo_q[axis_q]);
  assign diff   = MUL_W'(mapped_q[axis_q]) - MUL_W'(fv_q[axis_q]);
  assign k_eff  = (k_q > K_ONE) ? K_ONE : k_q;

  // shared multiplier: scaled offset, then filter step
  assign mul_a = (state_q == ST_FLT_MUL) ? diff : MUL_W'(offset);
  assign mul_b = (state_q == ST_FLT_MUL) ? $signed({{(MUL_W-K_W){1'b0}}, k_eff}) : OUT_SPAN;

  acl_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // divider request
  assign div_req.start = (state_q == ST_MAP_DIV) && (span != '0);
  assign div_req.num   = prod[NUM_W-1:0];
  assign div_req.den   = span;

  acl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // mapped value and filter update
  assign map_sum = PROD_W'(OUT_MIN_V)
                 + {{(PROD_W-QUOT_W){div_rsp.quot[QUOT_W-1]}}, div_rsp.quot};
  assign step    = (prod + ROUND_HALF) >>> K_FRAC;
  assign upd     = PROD_W'(fv_q[axis_q]) + step;

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      in_q        <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        mapped_q[a] <= '0;
        fv_q[a]     <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            axis_q  <= '0;
            err_q   <= '0;
            state_q <= ST_MAP_MUL;
          end
        end
        ST_MAP_MUL: begin
          state_q <= ST_MAP_DIV;
        end
        ST_MAP_DIV: begin
          if (span == '0) begin
            mapped_q[axis_q] <= OUT_MIN_V;
            err_q[axis_q]    <= 1'b1;
            state_q          <= ST_FLT_MUL;
          end else begin
            state_q <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            mapped_q[axis_q] <= sat24(map_sum);
            state_q          <= ST_FLT_MUL;
          end
        end
        ST_FLT_MUL: begin
          state_q <= ST_FLT_UPD;
        end
        ST_FLT_UPD: begin
          fv_q[axis_q] <= sat24(upd);
          if (axis_q == AXIS_W'(NUM_AXES - 1)) begin
            state_q <= ST_DONE;
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= ST_MAP_MUL;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.mapped_x   <= mapped_q[0];
            out_q.mapped_y   <= mapped_q[1];
            out_q.mapped_z   <= mapped_q[2];
            out_q.filtered_x <= fv_q[0];
            out_q.filtered_y <= fv_q[1];
            out_q.filtered_z <= fv_q[2];
            out_q.span_error <= err_q;
            out_valid_q      <= 1'b1;
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/acl_checker.sv
// ----------------------------------------------------------------------------
// acl_checker
// port-level checks of the calibrate and low-pass block, bound to the top
// ----------------------------------------------------------------------------
`include "axis_calibrate_lowpass_macros.svh"

module acl_checker import acl_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // an accepted item keeps the block busy in the next cycle
  `ACL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // a new result appears only at the end of work on an item
  `ACL_ASSERT_SAME(a_result_from_work, $rose(out_valid_o), $past(in_stall_o))

  // a stalled result stays offered
  `ACL_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result does not change
  `ACL_ASSERT_NEXT(a_out_data_holds, out_valid_o && out_stall_i, $stable(out_data_o))

endmodule

bind axis_calibrate_lowpass acl_checker u_acl_checker (.*);
